### hdl/lpht_pkg.sv
// Shared constants, codes and types for the linear-probing record table.
`timescale 1ns / 1ps

package lpht_pkg;

  // Default geometry
  localparam int CAPACITY     = 1024;
  localparam int RECORD_WIDTH = 32;
  localparam int KEY_W        = 64;

  // Finalizer mix constants
  localparam logic [KEY_W-1:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int               MIX_SHIFT = 33;

  // Request actions
  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Answer codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RESERVED  = 2'd3
  } status_t;

endpackage

### hdl/linear_probe_hash_table.sv
// Keyed record table with open addressing, linear probing and tombstones.
// Flow: the key is hashed in lpht_mix, then slots are probed one a cycle from the hashed
//   slot; a find that hits reads its record in S_REC before the result beat.
// Only one request is in work at a time; a new one is taken only back in idle.
// Clear: every key slot is emptied, one key slot written a cycle, then an OK answer.
// Reset: a pass over every slot empties the key store; req_stall stays high till done.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
  parameter int CAPACITY     = lpht_pkg::CAPACITY,
  parameter int RECORD_WIDTH = lpht_pkg::RECORD_WIDTH,
  localparam int SLOT_W  = $clog2(CAPACITY),
  localparam int COUNT_W = SLOT_W + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 action,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  input  logic [RECORD_WIDTH-1:0]    value,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [1:0]                 status,
  output logic [RECORD_WIDTH-1:0]    record_out,
  output logic [SLOT_W-1:0]          slot_index,
  output logic [COUNT_W-1:0]         live_count,
  output logic [COUNT_W-1:0]         occupied_count
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_REC,
    S_DONE
  } state_t;

  state_t                     state;
  logic [SLOT_W-1:0]          clr_idx;
  logic                       clr_reply;
  lpht_pkg::action_t          act;
  logic [lpht_pkg::KEY_W-1:0] req_key;
  logic [RECORD_WIDTH-1:0]    req_value;
  logic [SLOT_W-1:0]          probe_slot;
  logic [SLOT_W-1:0]          probe_cnt;
  logic [COUNT_W-1:0]         live_entries;
  logic [COUNT_W-1:0]         used_slots;
  lpht_pkg::status_t          res_status;
  logic [RECORD_WIDTH-1:0]    res_record;
  logic [SLOT_W-1:0]          res_slot;

  logic                       reserved;
  logic                       mix_start;
  logic                       mix_done;
  logic [lpht_pkg::KEY_W-1:0] mix_out;

  logic                       key_we;
  logic [SLOT_W-1:0]          key_waddr;
  logic [lpht_pkg::KEY_W-1:0] key_wdata;
  logic [SLOT_W-1:0]          key_raddr;
  logic [lpht_pkg::KEY_W-1:0] key_rdata;
  logic                       rec_we;
  logic [RECORD_WIDTH-1:0]    rec_rdata;

  logic                       k_empty;
  logic                       k_tomb;
  logic                       k_match;
  logic                       last_probe;

  assign req_stall = (state != S_IDLE);
  assign reserved  = (key == '0) || (&key);
  assign mix_start = (state == S_IDLE) && req_valid &&
                     (lpht_pkg::action_t'(action) != lpht_pkg::ACT_CLEAR) && !reserved;

  // Classify the slot just read
  assign k_empty    = (key_rdata == '0);
  assign k_tomb     = &key_rdata;
  assign k_match    = (key_rdata == req_key);
  assign last_probe = &probe_cnt;

  // Read ahead one slot while probing continues
  assign key_raddr = (state == S_CHECK) ? probe_slot + 1'b1 : probe_slot;

  // Key and record store write port
  always_comb begin
    key_we    = 1'b0;
    rec_we    = 1'b0;
    key_waddr = probe_slot;
    key_wdata = req_key;
    case (state)
      S_CLR: begin
        key_we    = 1'b1;
        key_waddr = clr_idx;
        key_wdata = '0;
      end
      S_CHECK: begin
        if (act == lpht_pkg::ACT_PUT && (k_empty || k_tomb)) begin
          key_we = 1'b1;
          rec_we = 1'b1;
        end else if (act == lpht_pkg::ACT_REMOVE && k_match) begin
          key_we    = 1'b1;
          key_wdata = '1;
        end
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  lpht_mix u_mix (
    .clk     (clk),
    .rst     (rst),
    .start   (mix_start),
    .key     (key),
    .done    (mix_done),
    .mix_out (mix_out)
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  lpht_ram #(
    .WIDTH (RECORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (probe_slot),
    .wdata (req_value),
    .raddr (probe_slot),
    .rdata (rec_rdata)
  );

  // Request sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      clr_reply    <= 1'b0;
      live_entries <= '0;
      used_slots   <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) begin
            if (clr_reply) begin
              res_status <= lpht_pkg::STAT_OK;
              res_record <= '0;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            act       <= lpht_pkg::action_t'(action);
            req_key   <= key;
            req_value <= value;
            if (lpht_pkg::action_t'(action) == lpht_pkg::ACT_CLEAR) begin
              clr_idx      <= '0;
              clr_reply    <= 1'b1;
              live_entries <= '0;
              used_slots   <= '0;
              state        <= S_CLR;
            end else if (reserved) begin
              res_status <= lpht_pkg::STAT_RESERVED;
              res_record <= '0;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (mix_done) begin
            probe_slot <= mix_out[SLOT_W-1:0];
            probe_cnt  <= '0;
            state      <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_record <= '0;
          if (act == lpht_pkg::ACT_PUT) begin
            if (k_empty || k_tomb) begin
              if (k_empty) begin
                used_slots <= used_slots + 1'b1;
              end
              live_entries <= live_entries + 1'b1;
              res_status   <= lpht_pkg::STAT_OK;
              res_slot     <= probe_slot;
              state        <= S_DONE;
            end else if (last_probe) begin
              res_status <= lpht_pkg::STAT_FULL;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              probe_slot <= probe_slot + 1'b1;
              probe_cnt  <= probe_cnt + 1'b1;
            end
          end else begin
            if (k_match) begin
              res_status <= lpht_pkg::STAT_OK;
              res_slot   <= probe_slot;
              if (act == lpht_pkg::ACT_REMOVE) begin
                if (live_entries != '0) begin
                  live_entries <= live_entries - 1'b1;
                end
                state <= S_DONE;
              end else begin
                state <= S_REC;
              end
            end else if (k_empty || last_probe) begin
              res_status <= lpht_pkg::STAT_NOT_FOUND;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              probe_slot <= probe_slot + 1'b1;
              probe_cnt  <= probe_cnt + 1'b1;
            end
          end
        end
        S_REC: begin
          res_record <= rec_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            status         <= res_status;
            record_out     <= res_record;
            slot_index     <= res_slot;
            live_count     <= live_entries;
            occupied_count <= used_slots;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Tombstones only add to the occupied count
  assert property (@(posedge clk) disable iff (rst) used_slots >= live_entries)
    else $error("occupied count below live count");

  // Occupied count never passes the capacity
  assert property (@(posedge clk) disable iff (rst)
                   used_slots <= COUNT_W'(CAPACITY))
    else $error("occupied count above capacity");

  // A miss, a full table or a reserved key carries no slot and no record
  assert property (@(posedge clk) disable iff (rst)
                   rsp_valid && status != 2'(lpht_pkg::STAT_OK)
                   |-> slot_index == '0 && record_out == '0)
    else $error("failed answer carries slot or record");

  // A clear answers with both counts empty
  assert property (@(posedge clk) disable iff (rst)
                   $past(state) == S_CLR && state == S_DONE
                   |-> live_entries == '0 && used_slots == '0)
    else $error("counts not zero after clear");

endmodule

### hdl/lpht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lpht_mix.sv
// 64-bit finalizer mix of a key, computed on one shared 32x32 multiplier.
`timescale 1ns / 1ps

module lpht_mix (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [lpht_pkg::KEY_W-1:0] mix_out
);

  typedef enum logic {
    M_IDLE,
    M_RUN
  } mix_state_t;

  // Steps of one 64x64 low-half product
  typedef enum logic [1:0] {
    P_LO,
    P_CROSS1,
    P_CROSS2,
    P_FOLD
  } phase_t;

  mix_state_t                 state;
  phase_t                     phase;
  logic                       round;
  logic [lpht_pkg::KEY_W-1:0] v;
  logic [lpht_pkg::KEY_W-1:0] prod;
  logic [lpht_pkg::KEY_W-1:0] acc;

  logic [lpht_pkg::KEY_W-1:0] coef;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [63:0]                mul_p;
  logic [lpht_pkg::KEY_W-1:0] sum;

  // Select the partial product for this step
  always_comb begin
    coef  = round ? lpht_pkg::MIX_C2 : lpht_pkg::MIX_C1;
    mul_a = (phase == P_CROSS2) ? v[63:32] : v[31:0];
    mul_b = (phase == P_CROSS1) ? coef[63:32] : coef[31:0];
    mul_p = mul_a * mul_b;
    sum   = {acc[63:32] + prod[31:0], acc[31:0]};
  end

  assign mix_out = v;

  // Sequence: xor-shift, then two rounds of multiply and xor-shift
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      phase <= P_LO;
      round <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= (state == M_RUN) && (phase == P_FOLD) && round;
      case (state)
        M_IDLE: begin
          if (start) begin
            v     <= key ^ (key >> lpht_pkg::MIX_SHIFT);
            round <= 1'b0;
            phase <= P_LO;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          prod <= mul_p;
          case (phase)
            P_LO: begin
              phase <= P_CROSS1;
            end
            P_CROSS1: begin
              acc   <= prod;
              phase <= P_CROSS2;
            end
            P_CROSS2: begin
              acc[63:32] <= acc[63:32] + prod[31:0];
              phase      <= P_FOLD;
            end
            P_FOLD: begin
              v     <= sum ^ (sum >> lpht_pkg::MIX_SHIFT);
              phase <= P_LO;
              round <= 1'b1;
              if (round) begin
                state <= M_IDLE;
              end
            end
            default: begin
              phase <= P_LO;
            end
          endcase
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule
